// ===== rtl/mmsw_pkg.sv =====
// Package for the MIDI monophonic square-wave synthesizer.
// Holds the key frequency table, MIDI codes, register indexes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package mmsw_pkg;

  localparam int SAMPLE_RATE_HZ = 48000;

  localparam int LVL_W  = 24;
  localparam int VOL_W  = 16;
  localparam int FREQ_W = 14;
  localparam int CNT_W  = 16;
  localparam int KEYS   = 128;

  // MIDI codes.
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] MIDI_CTRL   = 4'hB;
  localparam logic [6:0] CC_VOLUME   = 7'd7;
  localparam logic [7:0] NO_KEY      = 8'd255;

  // Volume scaling divides by the top MIDI value; the reciprocal is used by
  // the scaling stages as floor(2^VOL_SHIFT / VOL_STEPS).
  localparam int          VOL_STEPS = 127;
  localparam int          VOL_SHIFT = 30;
  localparam logic [23:0] VOL_RECIP = 24'((64'd1 << VOL_SHIFT) / VOL_STEPS);

  // Result kinds, carried on tuser.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_VOLUME = 1'b1;

  // Input actions, carried on tuser.
  localparam logic ACT_MIDI = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_LOW_LEVEL  = 3'd0;
  localparam logic [2:0] CFG_HIGH_LEVEL = 3'd1;
  localparam logic [2:0] CFG_NULL_LEVEL = 3'd2;
  localparam logic [2:0] CFG_VOL_MIN    = 3'd3;
  localparam logic [2:0] CFG_VOL_MAX    = 3'd4;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_DATA1 = 2'd1,
    PH_DATA2 = 2'd2
  } parse_phase_t;

  typedef struct packed {
    logic signed [LVL_W-1:0] low_lvl;
    logic signed [LVL_W-1:0] high_lvl;
    logic signed [LVL_W-1:0] null_lvl;
    logic signed [VOL_W-1:0] vol_min;
    logic signed [VOL_W-1:0] vol_max;
  } cfg_t;

  // One result of the core: a sample, or an unscaled volume magnitude.
  typedef struct packed {
    logic                    vld;
    logic                    kind;
    logic signed [LVL_W-1:0] sample;
    logic [22:0]             mag;
    logic                    neg;
  } core_res_t;

  // Equal-tempered key frequencies in Hz, rounded half up.
  localparam logic [FREQ_W-1:0] KEY_HZ [KEYS] = '{
    14'd8, 14'd9, 14'd9, 14'd10, 14'd10, 14'd11, 14'd12, 14'd12, 14'd13, 14'd14,
    14'd15, 14'd15, 14'd16, 14'd17, 14'd18, 14'd19, 14'd21, 14'd22, 14'd23, 14'd24,
    14'd26, 14'd28, 14'd29, 14'd31, 14'd33, 14'd35, 14'd37, 14'd39, 14'd41, 14'd44,
    14'd46, 14'd49, 14'd52, 14'd55, 14'd58, 14'd62, 14'd65, 14'd69, 14'd73, 14'd78,
    14'd82, 14'd87, 14'd92, 14'd98, 14'd104, 14'd110, 14'd117, 14'd123, 14'd131,
    14'd139, 14'd147, 14'd156, 14'd165, 14'd175, 14'd185, 14'd196, 14'd208, 14'd220,
    14'd233, 14'd247, 14'd262, 14'd277, 14'd294, 14'd311, 14'd330, 14'd349, 14'd370,
    14'd392, 14'd415, 14'd440, 14'd466, 14'd494, 14'd523, 14'd554, 14'd587, 14'd622,
    14'd659, 14'd698, 14'd740, 14'd784, 14'd831, 14'd880, 14'd932, 14'd988, 14'd1047,
    14'd1109, 14'd1175, 14'd1245, 14'd1319, 14'd1397, 14'd1480, 14'd1568, 14'd1661,
    14'd1760, 14'd1865, 14'd1976, 14'd2093, 14'd2217, 14'd2349, 14'd2489, 14'd2637,
    14'd2794, 14'd2960, 14'd3136, 14'd3322, 14'd3520, 14'd3729, 14'd3951, 14'd4186,
    14'd4435, 14'd4699, 14'd4978, 14'd5274, 14'd5588, 14'd5920, 14'd6272, 14'd6645,
    14'd7040, 14'd7459, 14'd7902, 14'd8372, 14'd8870, 14'd9397, 14'd9956, 14'd10548,
    14'd11175, 14'd11840, 14'd12544
  };

endpackage

// ===== rtl/midi_mono_square_wave_synth.sv =====
// Top level of the MIDI monophonic square-wave synthesizer.
// Holds the configuration registers, the volume scaling stages and the output.
// Depends on mmsw_pkg and mmsw_core.
`timescale 1ns / 1ps

// Usage:
// The input stream carries one item per transfer: in_tuser high is a sample
// tick, in_tuser low is a serial MIDI byte in in_tdata. Every tick yields one
// sample result (out_tuser low, level in out_tdata[23:0]); a completed
// control change 7 yields one volume result (out_tuser high, value in
// out_tdata[39:24]). Other MIDI bytes yield nothing.
// Throughput is one item per cycle unless the receiver stalls. A result passes
// stage A (scaled product), stage B (reciprocal quotient estimate of the divide
// by 127) and the output register (rounding correction). The three stages close
// up bubbles, so a stalled receiver blocks the input only once all three hold
// results. Configuration registers are written through cfg_we, cfg_index,
// cfg_wdata only while no item is in flight; this binds the user, and the block
// does not enforce it. The synchronous reset restores the register defaults,
// silences the tone, restarts the parser and empties the stages.
module midi_mono_square_wave_synth (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] midi_byte
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [23:0] sample_level, [39:24] volume_control
  output logic        out_tuser,  // [0] kind
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);
  import mmsw_pkg::*;

  cfg_t      cfg_r;
  core_res_t core_res;
  logic      in_xfer;

  // Stage A: core result.
  logic              a_vld_r;
  logic              a_kind_r;
  logic [LVL_W-1:0]  a_sample_r;
  logic [22:0]       a_mag_r;
  logic              a_neg_r;
  // Stage B: reciprocal quotient estimate.
  logic              b_vld_r;
  logic              b_kind_r;
  logic [LVL_W-1:0]  b_sample_r;
  logic [22:0]       b_mag_r;
  logic              b_neg_r;
  logic [15:0]       b_q0_r;
  logic [15:0]       b_q0_nxt;
  // Output register.
  logic              o_vld_r;
  logic              o_kind_r;
  logic [39:0]       o_data_r;
  logic [39:0]       o_data_nxt;

  logic              a_en, b_en, o_en;
  logic [46:0]       recip_prod;
  logic [23:0]       rem_c;
  logic [16:0]       q_c;
  logic signed [17:0] q_signed;
  logic signed [17:0] vol_sum;

  assign o_en      = !o_vld_r || out_tready;
  assign b_en      = !b_vld_r || o_en;
  assign a_en      = !a_vld_r || b_en;
  assign in_tready = a_en;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_lvl  <= -24'sd6553;
      cfg_r.high_lvl <= 24'sd6553;
      cfg_r.null_lvl <= '0;
      cfg_r.vol_min  <= '0;
      cfg_r.vol_max  <= 16'sd127;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOW_LEVEL:  cfg_r.low_lvl  <= cfg_wdata;
        CFG_HIGH_LEVEL: cfg_r.high_lvl <= cfg_wdata;
        CFG_NULL_LEVEL: cfg_r.null_lvl <= cfg_wdata;
        CFG_VOL_MIN:    cfg_r.vol_min  <= cfg_wdata[VOL_W-1:0];
        CFG_VOL_MAX:    cfg_r.vol_max  <= cfg_wdata[VOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mmsw_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_xfer),
    .action    (in_tuser),
    .midi_byte (in_tdata),
    .cfg       (cfg_r),
    .res       (core_res)
  );

  // Quotient estimate of mag / 127; it is exact or one short.
  assign recip_prod = {24'd0, a_mag_r} * {23'd0, VOL_RECIP};
  assign b_q0_nxt   = recip_prod[VOL_SHIFT+15:VOL_SHIFT];

  // The remainder uses 127 * q0 = 128 * q0 - q0.
  assign rem_c    = {1'b0, b_mag_r} - {1'b0, b_q0_r, 7'd0} + {8'd0, b_q0_r};
  assign q_c      = {1'b0, b_q0_r} + 17'(rem_c >= 24'(VOL_STEPS));
  assign q_signed = b_neg_r ? -$signed({1'b0, q_c}) : $signed({1'b0, q_c});
  assign vol_sum  = q_signed + {{2{cfg_r.vol_min[VOL_W-1]}}, cfg_r.vol_min};

  always_comb begin
    if (b_kind_r == KIND_VOLUME) begin
      o_data_nxt = {vol_sum[VOL_W-1:0], {LVL_W{1'b0}}};
    end else begin
      o_data_nxt = {{VOL_W{1'b0}}, b_sample_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      if (a_en) a_vld_r <= in_xfer && core_res.vld;
      if (b_en) b_vld_r <= a_vld_r;
      if (o_en) o_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_kind_r   <= core_res.kind;
      a_sample_r <= core_res.sample;
      a_mag_r    <= core_res.mag;
      a_neg_r    <= core_res.neg;
    end
    if (b_en) begin
      b_kind_r   <= a_kind_r;
      b_sample_r <= a_sample_r;
      b_mag_r    <= a_mag_r;
      b_neg_r    <= a_neg_r;
      b_q0_r     <= b_q0_nxt;
    end
    if (o_en) begin
      o_kind_r <= b_kind_r;
      o_data_r <= o_data_nxt;
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tuser  = o_kind_r;
  assign out_tdata  = o_data_r;

`ifndef SYNTHESIS
  // The input is held off only when every stage is full and the output stalls.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (a_vld_r && b_vld_r && o_vld_r && !out_tready))
    else $error("input stalled while a stage is free");

  // A volume result carries no sample bits.
  a_vol_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_VOLUME) |-> (out_tdata[LVL_W-1:0] == '0))
    else $error("volume result with nonzero sample field");

  // A sample result carries no volume bits.
  a_smp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_SAMPLE) |-> (out_tdata[39:LVL_W] == '0))
    else $error("sample result with nonzero volume field");

  // A blocked middle stage keeps its quotient estimate.
  a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b_vld_r && !o_en) |=> (b_vld_r && $stable(b_q0_r)))
    else $error("stage B changed while blocked");
`endif

endmodule

// ===== rtl/mmsw_core.sv =====
// MIDI parser and square-wave tone state of the synthesizer.
// Updates its state on each accepted item and returns that item's result.
// Depends on mmsw_pkg.
`timescale 1ns / 1ps

module mmsw_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               action,
  input  logic [7:0]         midi_byte,
  input  mmsw_pkg::cfg_t     cfg,
  output mmsw_pkg::core_res_t res
);
  import mmsw_pkg::*;

  parse_phase_t       phase_r, phase_nxt;
  logic [7:0]         status_r, status_nxt;
  logic [6:0]         first_r, first_nxt;
  logic [7:0]         key_r, key_nxt;
  logic [FREQ_W-1:0]  tone_r, tone_nxt;
  logic [FREQ_W-1:0]  prev_r, prev_nxt;
  logic [CNT_W-1:0]   delay_r, delay_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [LVL_W-1:0]   wave_r, wave_nxt;

  // Half-period in ticks for every key, fixed at elaboration.
  logic [CNT_W-1:0] key_delay [KEYS];

  for (genvar k = 0; k < KEYS; k++) begin : g_delay
    localparam int DLY = (SAMPLE_RATE_HZ / 2 + int'(KEY_HZ[k]) / 2) / int'(KEY_HZ[k]);
    assign key_delay[k] = CNT_W'(DLY);
  end

  logic               status_ok;
  logic [6:0]         data7;
  logic signed [16:0] span;
  logic [15:0]        span_mag;
  logic [22:0]        vol_mag;
  logic [CNT_W-1:0]   cnt_base;
  logic [CNT_W-1:0]   cnt_inc;

  assign status_ok = (midi_byte[7:5] == 3'b100) || (midi_byte[7:4] == MIDI_CTRL);
  assign data7     = midi_byte[6:0];
  assign span      = {cfg.vol_max[VOL_W-1], cfg.vol_max} - {cfg.vol_min[VOL_W-1], cfg.vol_min};
  assign span_mag  = span[16] ? 16'(-span) : span[15:0];
  assign vol_mag   = {7'd0, span_mag} * {16'd0, data7};
  assign cnt_base  = (tone_r != prev_r) ? '0 : cnt_r;
  assign cnt_inc   = cnt_base + 1'b1;

  always_comb begin
    phase_nxt  = phase_r;
    status_nxt = status_r;
    first_nxt  = first_r;
    key_nxt    = key_r;
    tone_nxt   = tone_r;
    prev_nxt   = prev_r;
    delay_nxt  = delay_r;
    cnt_nxt    = cnt_r;
    wave_nxt   = wave_r;
    res        = '0;

    if (action == ACT_TICK) begin
      res.vld    = step;
      res.kind   = KIND_SAMPLE;
      res.sample = cfg.null_lvl;
      prev_nxt   = tone_r;
      if (tone_r != '0) begin
        if (cnt_inc >= delay_r) begin
          cnt_nxt  = '0;
          wave_nxt = ($signed(wave_r) < $signed(cfg.high_lvl)) ? cfg.high_lvl : cfg.low_lvl;
        end else begin
          cnt_nxt = cnt_inc;
        end
        res.sample = $signed(wave_nxt);
      end else begin
        cnt_nxt = cnt_base;
      end
    end else if ((phase_r == PH_DATA1 || phase_r == PH_DATA2) && !midi_byte[7]) begin
      if (phase_r == PH_DATA1) begin
        first_nxt = data7;
        phase_nxt = PH_DATA2;
      end else begin
        phase_nxt = PH_WAIT;
        unique case (status_r[7:4])
          ST_NOTE_ON: begin
            if (data7 != '0) begin
              key_nxt   = {1'b0, first_r};
              tone_nxt  = KEY_HZ[first_r];
              delay_nxt = key_delay[first_r];
            end else if (key_r == {1'b0, first_r}) begin
              key_nxt  = NO_KEY;
              tone_nxt = '0;
            end
          end
          ST_NOTE_OFF: begin
            if (key_r == {1'b0, first_r}) begin
              key_nxt  = NO_KEY;
              tone_nxt = '0;
            end
          end
          MIDI_CTRL: begin
            if (first_r == CC_VOLUME) begin
              res.vld  = step;
              res.kind = KIND_VOLUME;
              res.mag  = vol_mag;
              res.neg  = span[16];
            end
          end
          default: begin
          end
        endcase
      end
    end else begin
      // A status byte in a data position lands here and restarts the parser.
      if (status_ok) begin
        status_nxt = midi_byte;
        phase_nxt  = PH_DATA1;
      end else begin
        phase_nxt = PH_WAIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      status_r <= '0;
      first_r  <= '0;
      key_r    <= NO_KEY;
      tone_r   <= '0;
      prev_r   <= '0;
      delay_r  <= '0;
      cnt_r    <= '0;
      wave_r   <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      status_r <= status_nxt;
      first_r  <= first_nxt;
      key_r    <= key_nxt;
      tone_r   <= tone_nxt;
      prev_r   <= prev_nxt;
      delay_r  <= delay_nxt;
      cnt_r    <= cnt_nxt;
      wave_r   <= wave_nxt;
    end
  end

endmodule
